@@ hdl/positional_list_engine_macros.svh @@
// Assertion shorthands, clocked on clk_i and held off during reset.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`define PLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/plen_pkg.sv @@
`default_nettype none

package plen_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_SHOW = 3'd1,
    OP_GET  = 3'd2,
    OP_INS  = 3'd3,
    OP_DEL  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2
  } cmd_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SHOW = 1'b1
  } fsm_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/plen_cell.sv @@
`default_nettype none

module plen_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                             clk_i,
  input  wire plen_pkg::cell_ctrl_t             ctrl_i,
  input  wire logic [IDX_W-1:0]                 at_i,
  input  wire logic signed [plen_pkg::DATA_W-1:0] left_i,
  input  wire logic signed [plen_pkg::DATA_W-1:0] right_i,
  output logic signed [plen_pkg::DATA_W-1:0]      word_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [plen_pkg::DATA_W-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (ctrl_i.cmd)
      plen_pkg::CMD_INS: begin
        if (MY_IDX > at_i) begin
          word_d = left_i;
        end else if (MY_IDX == at_i) begin
          word_d = ctrl_i.value;
        end
      end
      plen_pkg::CMD_DEL: begin
        if (MY_IDX >= at_i) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

@@ hdl/positional_list_engine.sv @@
// Ordered list of signed 32-bit words held in a row of CAPACITY cells, one word
// per cell. Insert, delete and push_front shift the cells past the position by
// one all at once; get reads one cell through a shared select. Input words
// (push_front, get, insert, delete) are taken back to back while the output
// side is not stalled; show enters its streaming state, then sends the listed
// elements in order, paced by the single output register. Input is stalled
// while a show streams or while a result waits in the output register. No
// clearing pass is needed after reset: cells past the element count are never read.
`default_nettype none

module positional_list_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [2:0]                          op_i,
  input  wire logic [15:0]                         position_i,
  input  wire logic signed [plen_pkg::DATA_W-1:0]  value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               status_o,
  output logic signed [plen_pkg::DATA_W-1:0]       data_o,
  output logic                                     last_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  plen_pkg::fsm_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic                                out_valid_q;
  plen_pkg::status_e                   status_q;
  logic signed [plen_pkg::DATA_W-1:0]  data_q;
  logic                                last_q;

  logic signed [plen_pkg::DATA_W-1:0] cell_word [CAPACITY];
  logic signed [plen_pkg::DATA_W-1:0] rd_data;
  logic [IDX_W-1:0]                   rd_addr;
  logic [IDX_W-1:0]                   at;
  plen_pkg::cell_ctrl_t               ctrl;

  logic              accept, slot_free, show_last, not_full, pos_in, pos_ins;
  logic [15:0]       pos_m1, cnt16;
  logic              load;
  plen_pkg::status_e ld_status;
  logic signed [plen_pkg::DATA_W-1:0] ld_data;
  logic              ld_last;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != plen_pkg::S_IDLE) || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_m1    = position_i - 16'd1;
  assign cnt16     = 16'(count_q);
  assign pos_in    = (position_i != 16'd0) && (position_i <= cnt16);
  assign pos_ins   = (position_i != 16'd0) && (position_i <= cnt16 + 16'd1);
  assign not_full  = count_q < CNT_W'(CAPACITY);
  assign show_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [plen_pkg::DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_body_l
      assign left_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_body_r
      assign right_w = cell_word[g+1];
    end
    plen_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .at_i    (at),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[g])
    );
  end

  always_comb begin
    rd_data = cell_word[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plen_pkg::S_IDLE: begin
        if (accept && (op_i == plen_pkg::OP_SHOW) && (count_q != '0)) begin
          state_d = plen_pkg::S_SHOW;
        end
      end
      plen_pkg::S_SHOW: begin
        if (slot_free && show_last) begin
          state_d = plen_pkg::S_IDLE;
        end
      end
      default: state_d = plen_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ctrl.cmd   = plen_pkg::CMD_HOLD;
    ctrl.value = value_i;
    at         = pos_m1[IDX_W-1:0];
    rd_addr    = pos_m1[IDX_W-1:0];
    count_d    = count_q;
    idx_d      = idx_q;
    load       = 1'b0;
    ld_status  = plen_pkg::ST_OK;
    ld_data    = '0;
    ld_last    = 1'b1;
    unique case (state_q)
      plen_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            plen_pkg::OP_PUSH: begin
              at = '0;
              if (not_full) begin
                ctrl.cmd = plen_pkg::CMD_INS;
                count_d  = count_q + CNT_W'(1);
              end
            end
            plen_pkg::OP_SHOW: begin
              idx_d = '0;
              if (count_q == '0) begin
                load      = 1'b1;
                ld_status = plen_pkg::ST_EMPTY;
              end
            end
            plen_pkg::OP_GET: begin
              load = 1'b1;
              if (pos_in) begin
                ld_data = rd_data;
              end else begin
                ld_status = plen_pkg::ST_FAIL;
              end
            end
            plen_pkg::OP_INS: begin
              load = 1'b1;
              if (pos_ins && not_full) begin
                ctrl.cmd = plen_pkg::CMD_INS;
                count_d  = count_q + CNT_W'(1);
              end else begin
                ld_status = plen_pkg::ST_FAIL;
              end
            end
            plen_pkg::OP_DEL: begin
              load = 1'b1;
              if (pos_in) begin
                ctrl.cmd = plen_pkg::CMD_DEL;
                count_d  = count_q - CNT_W'(1);
              end else begin
                ld_status = plen_pkg::ST_FAIL;
              end
            end
            default: load = 1'b0;
          endcase
        end
      end
      plen_pkg::S_SHOW: begin
        rd_addr = idx_q;
        if (slot_free) begin
          load    = 1'b1;
          ld_data = rd_data;
          ld_last = show_last;
          idx_d   = idx_q + IDX_W'(1);
        end
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plen_pkg::S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= ld_status;
      data_q   <= ld_data;
      last_q   <= ld_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

@@ hdl/plen_chk.sv @@
`default_nettype none

`include "positional_list_engine_macros.svh"

module plen_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic [31:0] data_o,
  input wire logic        last_o
);

  `PLE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(data_o) && $stable(status_o) && $stable(last_o))
  `PLE_ASSERT_NOW(a_fail_zero, out_valid_o && (status_o != plen_pkg::ST_OK), data_o == 32'd0)
  `PLE_ASSERT_NOW(a_empty_last, out_valid_o && (status_o == plen_pkg::ST_EMPTY), last_o)
  `PLE_ASSERT_NOW(a_fail_last, out_valid_o && (status_o == plen_pkg::ST_FAIL), last_o)
  `PLE_ASSERT_NOW(a_stall_full, out_valid_o && out_stall_i, in_stall_o)

endmodule

bind positional_list_engine plen_chk u_plen_chk (.*);

`default_nettype wire

@@ test/positional_list_engine_checker.sv @@
`default_nettype none

module positional_list_engine_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_stall_i,
  input  wire logic [2:0]                          op_i,
  input  wire logic [15:0]                         position_i,
  input  wire logic signed [plen_pkg::DATA_W-1:0]  value_i,
  input  wire logic                                out_valid_i,
  input  wire logic                                out_stall_i,
  input  wire logic [1:0]                          status_i,
  input  wire logic signed [plen_pkg::DATA_W-1:0]  data_i,
  input  wire logic                                last_i,
  output int                                       mismatch_count_o,
  output int                                       awaiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    plen_pkg::status_e                  status;
    logic signed [plen_pkg::DATA_W-1:0] data;
    logic                               last;
  } result_t;

  logic signed [plen_pkg::DATA_W-1:0] cells[$];
  result_t                            awaited_q[$];
  result_t                            head;
  int                                 mismatches;

  initial begin
    mismatch_count_o = 0;
    awaiting_o       = 0;
    mismatches       = 0;
  end

  function automatic void await_result(plen_pkg::status_e s,
                                       logic signed [plen_pkg::DATA_W-1:0] d, logic l);
    result_t r;
    r.status = s;
    r.data   = d;
    r.last   = l;
    awaited_q.push_back(r);
  endfunction

  // list behavior: positions are 1-based, cells[0] is the head
  function automatic void apply_command(logic [2:0] cmd, logic [15:0] pos,
                                        logic signed [plen_pkg::DATA_W-1:0] val);
    int n;
    n = cells.size();
    case (cmd)
      plen_pkg::OP_PUSH: begin
        if (n < CAPACITY) cells.push_front(val);
      end
      plen_pkg::OP_SHOW: begin
        if (n == 0) await_result(plen_pkg::ST_EMPTY, '0, 1'b1);
        else foreach (cells[i]) await_result(plen_pkg::ST_OK, cells[i], i == n - 1);
      end
      plen_pkg::OP_GET: begin
        if (pos >= 1 && pos <= n) await_result(plen_pkg::ST_OK, cells[pos - 1], 1'b1);
        else await_result(plen_pkg::ST_FAIL, '0, 1'b1);
      end
      plen_pkg::OP_INS: begin
        if (pos >= 1 && pos <= n + 1 && n < CAPACITY) begin
          cells.insert(pos - 1, val);
          await_result(plen_pkg::ST_OK, '0, 1'b1);
        end else begin
          await_result(plen_pkg::ST_FAIL, '0, 1'b1);
        end
      end
      plen_pkg::OP_DEL: begin
        if (pos >= 1 && pos <= n) begin
          cells.delete(pos - 1);
          await_result(plen_pkg::ST_OK, '0, 1'b1);
        end else begin
          await_result(plen_pkg::ST_FAIL, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells.delete();
      awaited_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) apply_command(op_i, position_i, value_i);
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result word with none expected: status %0d data %0d last %0d",
                   $realtime, status_i, data_i, last_i);
          mismatches++;
        end else begin
          head = awaited_q.pop_front();
          if (status_i !== head.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, head.status, status_i);
            mismatches++;
          end
          if (data_i !== head.data) begin
            $display("%0t: data expected %0d actual %0d", $realtime, head.data, data_i);
            mismatches++;
          end
          if (last_i !== head.last) begin
            $display("%0t: last expected %0d actual %0d", $realtime, head.last, last_i);
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    awaiting_o       <= awaited_q.size();
  end

endmodule

`default_nettype wire

@@ test/positional_list_engine_test.sv @@
`default_nettype none

module positional_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY       = 64;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 8;
  localparam logic [2:0]  OP_TOP         = 3'd7;

  logic                               clk;
  logic                               rst_n      = 1'b0;
  logic                               in_valid   = 1'b0;
  logic                               in_stall;
  logic [2:0]                         op         = plen_pkg::OP_PUSH;
  logic [15:0]                        position   = '0;
  logic signed [plen_pkg::DATA_W-1:0] value      = '0;
  logic                               out_valid;
  logic                               out_stall  = 1'b0;
  logic [1:0]                         status;
  logic signed [plen_pkg::DATA_W-1:0] data;
  logic                               last;

  int sender_gap_pct     = 31;
  int receiver_stall_pct = 77;
  int occupancy          = 0;
  int quiet_cycles       = 0;
  int mismatch_count;
  int awaiting;

  positional_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op),
    .position_i  (position),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .data_o      (data),
    .last_o      (last)
  );

  positional_list_engine_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .op_i             (op),
    .position_i       (position),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .data_i           (data),
    .last_i           (last),
    .mismatch_count_o (mismatch_count),
    .awaiting_o       (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("positional_list_engine regression: fail");
      $finish;
    end
  end

  // one word on the input channel; occupancy follows the list length
  task automatic send_word(input logic [2:0] w_op, input logic [15:0] w_pos,
                           input logic [plen_pkg::DATA_W-1:0] w_val);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= w_op;
    position <= w_pos;
    value    <= w_val;
    do @(posedge clk); while (in_stall);
    case (w_op)
      plen_pkg::OP_PUSH: if (occupancy < CAPACITY) occupancy++;
      plen_pkg::OP_INS: begin
        if (w_pos >= 1 && w_pos <= occupancy + 1 && occupancy < CAPACITY) occupancy++;
      end
      plen_pkg::OP_DEL: if (w_pos >= 1 && w_pos <= occupancy) occupancy--;
      default: ;
    endcase
  endtask

  task automatic run_phase(input int gap_pct, input int stall_pct, input int words);
    int          made;
    int          pick;
    int          top_ok;
    logic [2:0]  w_op;
    logic [15:0] w_pos;
    made               = 0;
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    while (made < words) begin
      pick = $urandom_range(99);
      if (pick < 5)       w_op = 3'($urandom_range(int'(OP_TOP), int'(plen_pkg::OP_DEL) + 1));
      else if (pick < 27) w_op = plen_pkg::OP_PUSH;
      else if (pick < 36) w_op = plen_pkg::OP_SHOW;
      else if (pick < 56) w_op = plen_pkg::OP_GET;
      else if (pick < 78) w_op = plen_pkg::OP_INS;
      else                w_op = plen_pkg::OP_DEL;
      top_ok = (w_op == plen_pkg::OP_INS) ? occupancy + 1 : occupancy;
      if ($urandom_range(99) < 80 && top_ok > 0) begin
        w_pos = 16'($urandom_range(top_ok, 1));
      end else begin
        case ($urandom_range(3))
          0:       w_pos = '0;
          1:       w_pos = 16'(top_ok + 1);
          2:       w_pos = '1;
          default: w_pos = 16'($urandom);
        endcase
      end
      send_word(w_op, w_pos, $urandom);
      if (w_op <= plen_pkg::OP_DEL) made++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, first/last and out-of-range positions, and unused opcodes
    send_word(plen_pkg::OP_SHOW, '0, '0);
    send_word(plen_pkg::OP_GET, '0, '0);
    send_word(plen_pkg::OP_GET, 16'd1, '0);
    send_word(plen_pkg::OP_INS, 16'd2, 32'h1234_5678);
    send_word(plen_pkg::OP_DEL, 16'd1, '0);
    send_word(plen_pkg::OP_INS, '0, 32'h1234_5678);
    send_word(plen_pkg::OP_INS, 16'd1, 32'h7fff_ffff);
    send_word(plen_pkg::OP_PUSH, '1, 32'h8000_0000);
    send_word(plen_pkg::OP_PUSH, '0, '0);
    send_word(plen_pkg::OP_PUSH, 16'h5555, '1);
    send_word(plen_pkg::OP_INS, 16'(occupancy + 1), 32'h5555_5555);
    send_word(plen_pkg::OP_INS, 16'(occupancy + 2), 32'haaaa_aaaa);
    send_word(plen_pkg::OP_INS, '1, 32'haaaa_aaaa);
    send_word(plen_pkg::OP_GET, 16'd1, '0);
    send_word(plen_pkg::OP_GET, 16'(occupancy), '0);
    send_word(plen_pkg::OP_GET, 16'(occupancy + 1), '0);
    send_word(plen_pkg::OP_GET, '1, '0);
    send_word(plen_pkg::OP_DEL, 16'(occupancy), '0);
    send_word(plen_pkg::OP_DEL, 16'd1, '0);
    send_word(plen_pkg::OP_DEL, '1, '0);
    send_word(plen_pkg::OP_DEL, '0, '0);
    send_word(plen_pkg::OP_SHOW, 16'haaaa, '1);
    for (int c = int'(plen_pkg::OP_DEL) + 1; c <= int'(OP_TOP); c++) begin
      send_word(3'(c), '1, 32'haaaa_aaaa);
    end

    // fill to capacity, then hit the full store
    while (occupancy < CAPACITY) begin
      if ($urandom_range(1)) send_word(plen_pkg::OP_PUSH, 16'($urandom), $urandom);
      else send_word(plen_pkg::OP_INS, 16'($urandom_range(occupancy + 1, 1)), $urandom);
    end
    send_word(plen_pkg::OP_PUSH, '0, 32'h0bad_0bad);
    send_word(plen_pkg::OP_INS, 16'd1, 32'h0bad_0bad);
    send_word(plen_pkg::OP_INS, 16'(CAPACITY + 1), 32'h0bad_0bad);
    send_word(plen_pkg::OP_GET, 16'(CAPACITY), '0);
    send_word(plen_pkg::OP_GET, 16'(CAPACITY + 1), '0);
    send_word(plen_pkg::OP_SHOW, '0, '0);

    run_phase(31, 77, 4);
    run_phase(77, 31, 4);
    run_phase(0, 0, 4);
    in_valid <= 1'b0;

    do @(posedge clk); while (awaiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("positional_list_engine regression: pass");
    end else begin
      $display("positional_list_engine regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
